// ----- src/wsp_pkg.sv -----
`default_nettype none

package wsp_pkg;

  localparam int DATA_W       = 16;
  localparam int GAIN_W       = 8;
  localparam int FRAC_W       = 6;
  localparam int SPEED_MAG_W  = 15;
  localparam int ERR_W        = DATA_W + 1;
  localparam int DIVIDEND_W   = DATA_W + FRAC_W;
  localparam int DIV_CNT_W    = $clog2(DIVIDEND_W + 1);
  localparam int GAIN_CNT_W   = $clog2(GAIN_W);
  localparam int CFG_IDX_W    = 3;
  localparam int IN_TDATA_W   = 40;
  localparam int IN_TUSER_W   = 1;
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_PAD_W    = OUT_TDATA_W - (2 * DATA_W + 1);

  localparam int WHEELS_DEF   = 2;
  localparam int INTEG_W_DEF  = 32;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 8'd4;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 8'd1;
  localparam logic [DATA_W-1:0] DUTY_LIMIT_RST = 16'd999;
  localparam logic [DATA_W-1:0] SPEED_SCALE_RST = 16'd16000;
  localparam logic [DATA_W-1:0] STOP_PERIOD_RST = 16'd10000;
  localparam logic [DATA_W-1:0] MIN_PERIOD_RST  = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_DUTY_LIMIT  = 3'd2,
    CFG_SPEED_SCALE = 3'd3,
    CFG_STOP_PERIOD = 3'd4,
    CFG_MIN_PERIOD  = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_SPEED,
    ST_ACCUM,
    ST_MAC,
    ST_DUTY
  } ctrl_state_e;

  typedef struct packed {
    logic s_ready;
    logic div_start;
    logic mac_start;
    logic out_load;
  } ctrl_out_t;

endpackage

`default_nettype wire

// ----- src/wsp_divider.sv -----
`default_nettype none

module wsp_divider (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [wsp_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  wire logic [wsp_pkg::DATA_W-1:0]      divisor_i,
  output logic                                 done_o,
  output logic [wsp_pkg::DIVIDEND_W-1:0]       quotient_o
);
  import wsp_pkg::*;

  logic [DIVIDEND_W-1:0] quo_q;
  logic [DATA_W-1:0]     rem_q;
  logic [DATA_W-1:0]     divisor_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [DATA_W:0]       rem_sh;
  logic [DATA_W+1:0]     diff;
  logic                  fits;

  assign rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor_q};
  assign fits   = ~diff[DATA_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(DIVIDEND_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- src/wsp_serial_mac.sv -----
`default_nettype none

module wsp_serial_mac #(
  parameter int INTEG_W = wsp_pkg::INTEG_W_DEF,
  localparam int ACC_W  = INTEG_W + wsp_pkg::GAIN_W + 2
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [wsp_pkg::ERR_W-1:0]  err_i,
  input  wire logic signed [INTEG_W-1:0]         integ_i,
  input  wire logic [wsp_pkg::GAIN_W-1:0]        prop_gain_i,
  input  wire logic [wsp_pkg::GAIN_W-1:0]        integ_gain_i,
  output logic                                   done_o,
  output logic signed [ACC_W-1:0]                acc_o
);
  import wsp_pkg::*;

  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W-1:0]   mcand_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic [GAIN_W-1:0]         gain_q;
  logic [GAIN_W-1:0]         ki_q;
  logic [GAIN_CNT_W-1:0]     cnt_q;
  logic                      phase_q;
  logic                      busy_q;
  logic                      done_q;
  logic                      last_bit;

  assign last_bit = (cnt_q == GAIN_CNT_W'(GAIN_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + GAIN_CNT_W'(1);
      if (last_bit) begin
        cnt_q <= '0;
        if (phase_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          phase_q <= 1'b1;
        end
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= '0;
      mcand_q <= ACC_W'(err_i);
      gain_q  <= prop_gain_i;
      ki_q    <= integ_gain_i;
      integ_q <= integ_i;
    end else if (busy_q) begin
      if (gain_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      if (last_bit && !phase_q) begin
        mcand_q <= ACC_W'(integ_q);
        gain_q  <= ki_q;
      end else begin
        mcand_q <= mcand_q <<< 1;
        gain_q  <= gain_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

// ----- src/wheel_speed_pi_control.sv -----
`default_nettype none
// PI speed controller for up to WHEELS wheels, one control tick per input beat.
// Input stream: s_axis_tuser carries the wheel number, s_axis_tdata the target
// speed (Q.6), the encoder capture period and the emergency flag. Output
// stream: one beat per tick with duty magnitude, reverse flag and the signed
// measured speed. Configuration: cfg_valid_i/cfg_index_i/cfg_data_i write
// gains, duty limit, speed scale and the period thresholds; always ready.
// A tick that needs scale/period runs a bit-serial restoring divider, one
// quotient bit per cycle, then a shift-add multiplier that takes one gain bit
// per cycle. Ticks that keep or zero the speed skip the divider, an emergency
// tick skips the multiplier (it still divides when it needs to) and a tick for
// an unknown wheel goes straight to the output. One tick is processed at a
// time; the next beat is taken the cycle after the result is loaded into the
// output register. A stalled receiver holds the output beat; the controller
// then accepts one more tick and waits with its result until the output
// register frees. Reset clears integrators, speeds and directions of all
// wheels and loads the default gains and limits.
module wheel_speed_pi_control #(
  parameter int WHEELS  = wsp_pkg::WHEELS_DEF,
  parameter int INTEG_W = wsp_pkg::INTEG_W_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [wsp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [wsp_pkg::DATA_W-1:0]       cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // target_speed[15:0], capture_period[31:16], emergency_stop[32], zero[39:33]
  input  wire logic [wsp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // wheel[0]
  input  wire logic [wsp_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // duty[15:0], reverse[16], measured_speed[32:17], zero[39:33]
  output logic [wsp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
  import wsp_pkg::*;

  localparam int ACC_W  = INTEG_W + GAIN_W + 2;
  localparam int WIDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam int SUM_W  = ((INTEG_W > ERR_W) ? INTEG_W : ERR_W) + 1;
  localparam logic signed [SUM_W-1:0] I_MAX =
    {{(SUM_W-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] I_MIN = ~I_MAX;

  ctrl_state_e state_q, state_d;
  ctrl_out_t   ctl;

  logic [GAIN_W-1:0] prop_gain_q, integ_gain_q;
  logic [DATA_W-1:0] duty_limit_q, speed_scale_q, stop_period_q, min_period_q;

  logic                      wheel_q;
  logic signed [DATA_W-1:0]  target_q;
  logic [DATA_W-1:0]         period_q;
  logic                      emerg_q;
  logic signed [DATA_W-1:0]  speed_q;
  logic signed [ERR_W-1:0]   err_q;

  logic signed [INTEG_W-1:0] integ_q [WHEELS];
  logic [SPEED_MAG_W-1:0]    mag_q   [WHEELS];
  logic                      dir_q   [WHEELS];

  logic                      m_valid_q;
  logic [DATA_W-1:0]         duty_q;
  logic                      rev_q;
  logic signed [DATA_W-1:0]  speed_out_q;

  logic [WIDX_W-1:0]         w_idx;
  logic                      in_range;
  logic                      is_stop, is_fast;
  logic                      div_done, mac_done;
  logic [DIVIDEND_W-1:0]     quotient;
  logic [SPEED_MAG_W-1:0]    quo_sat;
  logic signed [DATA_W-1:0]  speed_c;
  logic signed [SUM_W-1:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [ACC_W-1:0]   mac_acc;
  logic                      d_neg;
  logic [ACC_W-1:0]          d_mag;
  logic                      d_over;
  logic [DATA_W-1:0]         duty_c;
  logic                      rev_c;
  logic                      out_free;

  assign w_idx    = WIDX_W'(wheel_q);
  assign in_range = (int'(wheel_q) < WHEELS);
  assign is_stop  = (period_q > stop_period_q);
  assign is_fast  = (period_q > min_period_q);
  assign out_free = !m_valid_q || m_axis_tready;

  assign quo_sat = (|quotient[DIVIDEND_W-1:SPEED_MAG_W]) ? {SPEED_MAG_W{1'b1}}
                                                          : quotient[SPEED_MAG_W-1:0];
  assign speed_c = dir_q[w_idx] ? -$signed({1'b0, mag_q[w_idx]})
                                :  $signed({1'b0, mag_q[w_idx]});

  assign integ_sum = SUM_W'(integ_q[w_idx]) + SUM_W'(err_q);
  always_comb begin
    priority if (integ_sum > I_MAX) begin
      integ_sat = INTEG_W'(I_MAX);
    end else if (integ_sum < I_MIN) begin
      integ_sat = INTEG_W'(I_MIN);
    end else begin
      integ_sat = INTEG_W'(integ_sum);
    end
  end

  assign d_neg  = mac_acc[ACC_W-1];
  assign d_mag  = d_neg ? ACC_W'(-mac_acc) : ACC_W'(mac_acc);
  assign d_over = (d_mag >= ACC_W'({duty_limit_q, {FRAC_W{1'b0}}}));

  always_comb begin
    priority if (!in_range || emerg_q) begin
      duty_c = '0;
      rev_c  = 1'b0;
    end else begin
      duty_c = d_over ? duty_limit_q : d_mag[FRAC_W +: DATA_W];
      rev_c  = d_neg;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (!in_range) begin
          state_d = ST_DUTY;
        end else if (!is_stop && is_fast) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_SPEED;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_SPEED;
        end
      end
      ST_SPEED: state_d = ST_ACCUM;
      ST_ACCUM: state_d = emerg_q ? ST_DUTY : ST_MAC;
      ST_MAC: begin
        if (mac_done) begin
          state_d = ST_DUTY;
        end
      end
      ST_DUTY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    unique case (state_q)
      ST_IDLE:  ctl.s_ready   = 1'b1;
      ST_EVAL:  ctl.div_start = in_range && !is_stop && is_fast;
      ST_ACCUM: ctl.mac_start = !emerg_q;
      ST_DUTY:  ctl.out_load  = out_free;
      default:  ctl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= PROP_GAIN_RST;
      integ_gain_q  <= INTEG_GAIN_RST;
      duty_limit_q  <= DUTY_LIMIT_RST;
      speed_scale_q <= SPEED_SCALE_RST;
      stop_period_q <= STOP_PERIOD_RST;
      min_period_q  <= MIN_PERIOD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PROP_GAIN:   prop_gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEG_GAIN:  integ_gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_DUTY_LIMIT:  duty_limit_q  <= cfg_data_i;
        CFG_SPEED_SCALE: speed_scale_q <= cfg_data_i;
        CFG_STOP_PERIOD: stop_period_q <= cfg_data_i;
        CFG_MIN_PERIOD:  min_period_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.s_ready && s_axis_tvalid) begin
      wheel_q  <= s_axis_tuser[0];
      target_q <= s_axis_tdata[DATA_W-1:0];
      period_q <= s_axis_tdata[2*DATA_W-1:DATA_W];
      emerg_q  <= s_axis_tdata[2*DATA_W];
    end
    if (state_q == ST_SPEED) begin
      speed_q <= speed_c;
      err_q   <= ERR_W'(target_q) - ERR_W'(speed_c);
    end
  end

  // per-wheel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WHEELS; k++) begin
        integ_q[k] <= '0;
        mag_q[k]   <= '0;
        dir_q[k]   <= 1'b0;
      end
    end else begin
      if (state_q == ST_EVAL && in_range && is_stop) begin
        mag_q[w_idx] <= '0;
      end
      if (state_q == ST_DIV && div_done) begin
        mag_q[w_idx] <= quo_sat;
      end
      if (state_q == ST_ACCUM) begin
        integ_q[w_idx] <= emerg_q ? '0 : integ_sat;
      end
      if (ctl.out_load && in_range) begin
        dir_q[w_idx] <= rev_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      duty_q      <= duty_c;
      rev_q       <= rev_c;
      speed_out_q <= in_range ? speed_q : '0;
    end
  end

  wsp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i ({speed_scale_q, {FRAC_W{1'b0}}}),
    .divisor_i  (period_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  wsp_serial_mac #(
    .INTEG_W (INTEG_W)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (ctl.mac_start),
    .err_i        (err_q),
    .integ_i      (integ_sat),
    .prop_gain_i  (prop_gain_q),
    .integ_gain_i (integ_gain_q),
    .done_o       (mac_done),
    .acc_o        (mac_acc)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ctl.s_ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, speed_out_q, rev_q, duty_q};

`ifndef SYNTH
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_mac_done_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_MAC))
    else $error("multiplier finished outside the multiply phase");

  a_out_from_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == ST_DUTY))
    else $error("output beat raised outside the duty phase");

  a_mac_not_on_emerg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.mac_start |-> (!emerg_q && in_range))
    else $error("multiplier started on an emergency or unknown wheel tick");
`endif

endmodule

`default_nettype wire

// ----- test/wsp_tick_checker.sv -----
module wsp_tick_checker #(
  parameter int WHEELS  = wsp_pkg::WHEELS_DEF,
  parameter int INTEG_W = wsp_pkg::INTEG_W_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wsp_pkg::DATA_W-1:0]      cfg_data_i,
  input  logic                            s_valid_i,
  input  logic                            s_ready_i,
  // target_speed[15:0], capture_period[31:16], emergency_stop[32], zero[39:33]
  input  logic [wsp_pkg::IN_TDATA_W-1:0]  s_data_i,
  // wheel[0]
  input  logic [wsp_pkg::IN_TUSER_W-1:0]  s_user_i,
  input  logic                            m_valid_i,
  input  logic                            m_ready_i,
  // duty[15:0], reverse[16], measured_speed[32:17], zero[39:33]
  input  logic [wsp_pkg::OUT_TDATA_W-1:0] m_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import wsp_pkg::*;

  localparam longint INTEG_MAX = (64'sd1 <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;

  typedef struct packed {
    logic [DATA_W-1:0] duty;
    logic              reverse;
    logic [DATA_W-1:0] speed;
  } drive_t;

  logic [GAIN_W-1:0] prop_gain_q;
  logic [GAIN_W-1:0] integ_gain_q;
  logic [DATA_W-1:0] duty_limit_q;
  logic [DATA_W-1:0] speed_scale_q;
  logic [DATA_W-1:0] stop_period_q;
  logic [DATA_W-1:0] min_period_q;

  longint            integ_q     [WHEELS];
  logic [DATA_W-1:0] speed_mag_q [WHEELS];
  logic              reverse_q   [WHEELS];

  drive_t            drive_due_q [$];
  int                mismatches;

  function automatic drive_t pi_tick(input int unsigned wheel,
                                     input logic signed [DATA_W-1:0] target,
                                     input logic [DATA_W-1:0] period,
                                     input logic estop);
    drive_t res;
    longint quot;
    longint speed;
    longint err;
    longint sum;
    longint demand;
    longint mag;
    res = '0;
    if (wheel >= WHEELS) return res;
    if (period > stop_period_q) begin
      speed_mag_q[wheel] = '0;
    end else if (period > min_period_q) begin
      quot = (longint'(speed_scale_q) * 64) / longint'(period);
      speed_mag_q[wheel] = (quot > 32767) ? 16'd32767 : quot[DATA_W-1:0];
    end
    speed = reverse_q[wheel] ? -longint'(speed_mag_q[wheel]) : longint'(speed_mag_q[wheel]);
    err = longint'(target) - speed;
    sum = integ_q[wheel] + err;
    integ_q[wheel] = (sum > INTEG_MAX) ? INTEG_MAX : ((sum < INTEG_MIN) ? INTEG_MIN : sum);
    demand = longint'(prop_gain_q) * err + longint'(integ_gain_q) * integ_q[wheel];
    if (estop) begin
      integ_q[wheel] = 0;
    end else begin
      res.reverse = (demand < 0);
      mag = (demand < 0) ? -demand : demand;
      res.duty = (mag >= longint'(duty_limit_q) * 64) ? duty_limit_q
                                                      : mag[DATA_W+FRAC_W-1:FRAC_W];
    end
    reverse_q[wheel] = res.reverse;
    res.speed = speed[DATA_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    drive_t got;
    drive_t want;
    if (!rst_ni) begin
      prop_gain_q   = PROP_GAIN_RST;
      integ_gain_q  = INTEG_GAIN_RST;
      duty_limit_q  = DUTY_LIMIT_RST;
      speed_scale_q = SPEED_SCALE_RST;
      stop_period_q = STOP_PERIOD_RST;
      min_period_q  = MIN_PERIOD_RST;
      for (int k = 0; k < WHEELS; k++) begin
        integ_q[k]     = 0;
        speed_mag_q[k] = '0;
        reverse_q[k]   = 1'b0;
      end
      drive_due_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PROP_GAIN:   prop_gain_q   = cfg_data_i[GAIN_W-1:0];
          CFG_INTEG_GAIN:  integ_gain_q  = cfg_data_i[GAIN_W-1:0];
          CFG_DUTY_LIMIT:  duty_limit_q  = cfg_data_i;
          CFG_SPEED_SCALE: speed_scale_q = cfg_data_i;
          CFG_STOP_PERIOD: stop_period_q = cfg_data_i;
          CFG_MIN_PERIOD:  min_period_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        drive_due_q.push_back(pi_tick(s_user_i[0], s_data_i[DATA_W-1:0],
                                      s_data_i[2*DATA_W-1:DATA_W], s_data_i[2*DATA_W]));
      end
      if (m_valid_i && m_ready_i) begin
        got.duty    = m_data_i[DATA_W-1:0];
        got.reverse = m_data_i[DATA_W];
        got.speed   = m_data_i[2*DATA_W:DATA_W+1];
        if (drive_due_q.size() == 0) begin
          $error("output beat with no tick outstanding");
          mismatches++;
        end else begin
          want = drive_due_q.pop_front();
          if (got.duty !== want.duty) begin
            $error("duty: expected %0d, got %0d", want.duty, got.duty);
            mismatches++;
          end
          if (got.reverse !== want.reverse) begin
            $error("reverse: expected %0d, got %0d", want.reverse, got.reverse);
            mismatches++;
          end
          if (got.speed !== want.speed) begin
            $error("measured_speed: expected %0d, got %0d",
                   $signed(want.speed), $signed(got.speed));
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= drive_due_q.size();
    end
  end

endmodule

// ----- test/tb.sv -----
module tb;
  import wsp_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASES       = 7;
  localparam int PHASE_TICKS  = 170;
  localparam int SAT_TICKS    = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [DATA_W-1:0]      cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int                     fail_count;
  int                     pending;
  logic                   tx_calm  = 1'b0;
  logic                   rx_calm  = 1'b0;
  int unsigned            rx_wait  = 0;
  logic [DATA_W-1:0]      cur_stop = STOP_PERIOD_RST;
  logic [DATA_W-1:0]      cur_min  = MIN_PERIOD_RST;

  wheel_speed_pi_control u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  wsp_tick_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hold ready low for the drawn number of cycles a beat is offered
  always @(posedge clk_i) begin : rx_pace
    int unsigned wait_next;
    wait_next = rx_wait;
    if (!rst_ni) begin
      wait_next = 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      wait_next = rx_calm ? 0 : $urandom_range(0, 7);
    end else if (m_axis_tvalid && wait_next != 0) begin
      wait_next--;
    end
    rx_wait       <= wait_next;
    m_axis_tready <= rst_ni && (wait_next == 0);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_tick(input logic wheel, input logic signed [DATA_W-1:0] target,
                           input logic [DATA_W-1:0] period, input logic estop);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - 2*DATA_W - 1){1'b0}}, estop, period, target};
    s_axis_tuser  <= wheel;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_regs(input logic [GAIN_W-1:0] pg, input logic [GAIN_W-1:0] ig,
                              input logic [DATA_W-1:0] limit, input logic [DATA_W-1:0] scale,
                              input logic [DATA_W-1:0] stop, input logic [DATA_W-1:0] min_p);
    write_reg(CFG_PROP_GAIN, {{(DATA_W - GAIN_W){1'b0}}, pg});
    write_reg(CFG_INTEG_GAIN, {{(DATA_W - GAIN_W){1'b0}}, ig});
    write_reg(CFG_DUTY_LIMIT, limit);
    write_reg(CFG_SPEED_SCALE, scale);
    write_reg(CFG_STOP_PERIOD, stop);
    write_reg(CFG_MIN_PERIOD, min_p);
    // unused index last: must not disturb the registers above
    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom()));
    cfg_valid_i <= 1'b0;
    cur_stop = stop;
    cur_min  = min_p;
  endtask

  function automatic logic [DATA_W-1:0] pick_value(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 3))
      0:       return DATA_W'(lo);
      1:       return DATA_W'(hi);
      default: return DATA_W'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_target();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1:       return DATA_W'(int'($urandom_range(0, 400)) - 200);
      default: return DATA_W'($urandom());
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_period();
    case ($urandom_range(0, 7))
      0:       return DATA_W'($urandom_range(0, cur_min));
      1:       return cur_min;
      2:       return cur_min + 16'd1;
      3:       return cur_stop;
      4:       return cur_stop + 16'd1;
      5:       return DATA_W'($urandom_range(1, 64));
      6:       return DATA_W'($urandom_range(cur_min, cur_stop));
      default: return DATA_W'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    logic [DATA_W-1:0] stop_v;
    logic [DATA_W-1:0] min_v;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: stopped, small negative demand, thresholds, emergency
    send_tick(1'b0, 16'sd0, 16'hFFFF, 1'b0);
    send_tick(1'b0, -16'sd1, 16'hFFFF, 1'b0);
    send_tick(1'b0, 16'sd100, 16'd10000, 1'b0);
    send_tick(1'b1, 16'sh7FFF, 16'd10001, 1'b0);
    send_tick(1'b1, 16'sh8000, 16'd50, 1'b0);
    send_tick(1'b1, 16'sh8000, 16'd51, 1'b0);
    send_tick(1'b0, 16'sh7FFF, 16'd0, 1'b1);
    send_tick(1'b0, 16'sd5000, 16'd0, 1'b0);
    send_tick(1'b1, 16'sd0, 16'd51, 1'b1);
    send_tick(1'b0, 16'sh8000, 16'hFFFF, 1'b0);
    drain();

    program_regs(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    send_tick(1'b0, 16'sh7FFF, 16'd1, 1'b0);
    send_tick(1'b1, 16'sh8000, 16'hFFFF, 1'b0);
    send_tick(1'b0, 16'sh8000, 16'd0, 1'b0);
    send_tick(1'b1, 16'sh7FFF, 16'd2, 1'b0);
    send_tick(1'b0, 16'sd0, 16'hFFFF, 1'b1);
    drain();

    program_regs(8'd0, 8'd0, 16'd0, 16'd1, 16'd0, 16'hFFFF);
    send_tick(1'b0, 16'sh7FFF, 16'd0, 1'b0);
    send_tick(1'b1, 16'sh8000, 16'd1, 1'b0);
    send_tick(1'b1, 16'sh8000, 16'hFFFF, 1'b1);
    drain();

    program_regs(8'd1, 8'd1, 16'd500, 16'd1, 16'hFFFF, 16'd0);
    send_tick(1'b0, 16'sd0, 16'hFFFF, 1'b0);
    send_tick(1'b0, 16'sd0, 16'd64, 1'b0);
    send_tick(1'b1, 16'sd0, 16'd1, 1'b0);
    send_tick(1'b1, 16'sh7FFF, 16'd65, 1'b0);
    drain();

    // wind the integrator of wheel 0 far negative with zero gains
    program_regs(8'd0, 8'd0, DUTY_LIMIT_RST, 16'hFFFF, 16'hFFFF, 16'd0);
    tx_calm = 1'b1;
    rx_calm <= 1'b1;
    send_tick(1'b0, 16'sd0, 16'd1, 1'b1);
    repeat (SAT_TICKS) send_tick(1'b0, 16'sh8000, 16'd0, 1'b0);
    drain();
    program_regs(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    send_tick(1'b0, 16'sh7FFF, 16'd0, 1'b0);
    send_tick(1'b0, 16'sh7FFF, 16'd0, 1'b0);
    send_tick(1'b0, 16'sd0, 16'd0, 1'b1);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        program_regs(PROP_GAIN_RST, INTEG_GAIN_RST, DUTY_LIMIT_RST, SPEED_SCALE_RST,
                     STOP_PERIOD_RST, MIN_PERIOD_RST);
      end else if (phase == 1) begin
        program_regs(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
      end else begin
        stop_v = pick_value(0, 65535);
        min_v  = ($urandom_range(0, 3) == 0) ? pick_value(0, 65535)
                                             : DATA_W'($urandom_range(0, stop_v));
        program_regs(GAIN_W'(pick_value(0, 255)), GAIN_W'(pick_value(0, 255)),
                     pick_value(0, 65535), pick_value(1, 65535), stop_v, min_v);
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm <= ($urandom_range(0, 3) == 0);
      repeat (PHASE_TICKS)
        send_tick(1'($urandom_range(0, 1)), pick_target(), pick_period(),
                  $urandom_range(0, 9) == 0);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
